// ===== hdl/pixel_bitmask_format_converter_assert.svh =====
// assertion helpers for the pixel format converter
`ifndef PIXEL_BITMASK_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_BITMASK_FORMAT_CONVERTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PBFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel format converter check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define PBFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel format converter check failed");

`endif

// ===== hdl/pbfc_pkg.sv =====
`default_nettype none
package pbfc_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned BPP_W     = 3;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CHAN  = 3;

  // pixel format codes
  localparam logic [1:0] FMT_RGBA     = 2'd0;
  localparam logic [1:0] FMT_BGRA     = 2'd1;
  localparam logic [1:0] FMT_BITMASK  = 2'd2;
  localparam logic [1:0] FMT_BLT_ONLY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_MASK = 3'd4;

  // fixed masks of the rgba layout
  localparam logic [PIX_W-1:0] RGBA_RED_MASK      = 32'h0000_00ff;
  localparam logic [PIX_W-1:0] RGBA_GREEN_MASK    = 32'h0000_ff00;
  localparam logic [PIX_W-1:0] RGBA_BLUE_MASK     = 32'h00ff_0000;
  localparam logic [PIX_W-1:0] RGBA_RESERVED_MASK = 32'hff00_0000;

  // top bit of each channel in the transfer pixel: red, green, blue
  localparam logic signed [6:0] CHAN_TOP [NUM_CHAN] = '{7'sd23, 7'sd15, 7'sd7};

  typedef struct packed {
    logic               found;
    logic [SHIFT_W-1:0] idx;
  } top_bit_t;

  typedef struct packed {
    logic [PIX_W-1:0]   mask;
    logic [SHIFT_W-1:0] lsh;
    logic [SHIFT_W-1:0] rsh;
  } chan_cfg_t;

  // everything the datapath needs, derived from the configuration registers
  typedef struct packed {
    logic [1:0]       fmt;
    chan_cfg_t [NUM_CHAN-1:0] chan;
    logic [BPP_W-1:0] bpp;
  } conv_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [BPP_W-1:0] bpp;
    logic             err;
  } conv_res_t;

  // highest set bit, priority encoded
  function automatic top_bit_t top_bit(input logic [PIX_W-1:0] v);
    top_bit_t t;
    t = '0;
    for (int i = 0; i < PIX_W; i++) begin
      if (v[i]) begin
        t.found = 1'b1;
        t.idx   = SHIFT_W'(i);
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pbfc_if.sv =====
`default_nettype none
interface pbfc_in_if;
  import pbfc_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output func, output pixel_in, input ready);
  modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface pbfc_out_if;
  import pbfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [BPP_W-1:0] bytes_per_pixel;
  logic             format_error;

  modport source (output valid, output pixel_out, output bytes_per_pixel,
                  output format_error, input ready);
  modport sink   (input valid, input pixel_out, input bytes_per_pixel,
                  input format_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/pbfc_shift_calc.sv =====
`default_nettype none
module pbfc_shift_calc
  import pbfc_pkg::*;
(
  input  wire logic [1:0]       fmt,
  input  wire logic [PIX_W-1:0] mask_red,
  input  wire logic [PIX_W-1:0] mask_green,
  input  wire logic [PIX_W-1:0] mask_blue,
  input  wire logic [PIX_W-1:0] reserved_mask,
  output conv_cfg_t             cfg
);

  logic [PIX_W-1:0] m [NUM_CHAN];
  logic [PIX_W-1:0] rsv;
  logic [PIX_W-1:0] all_m;
  top_bit_t         tb [NUM_CHAN];
  top_bit_t         tb_all;
  logic signed [6:0] h   [NUM_CHAN];
  logic signed [6:0] s   [NUM_CHAN];
  logic signed [6:0] neg [NUM_CHAN];

  always_comb begin
    if (fmt == FMT_RGBA) begin
      m[0] = RGBA_RED_MASK;
      m[1] = RGBA_GREEN_MASK;
      m[2] = RGBA_BLUE_MASK;
      rsv  = RGBA_RESERVED_MASK;
    end else begin
      m[0] = mask_red;
      m[1] = mask_green;
      m[2] = mask_blue;
      rsv  = reserved_mask;
    end
  end

  always_comb begin
    cfg.fmt = fmt;
    for (int i = 0; i < NUM_CHAN; i++) begin
      tb[i]  = top_bit(m[i]);
      // empty mask counts as top bit -1
      h[i]   = tb[i].found ? $signed({2'b00, tb[i].idx}) : -7'sd1;
      s[i]   = h[i] - CHAN_TOP[i];
      neg[i] = -s[i];
      cfg.chan[i].mask = m[i];
      cfg.chan[i].lsh  = (s[i] > 7'sd0) ? s[i][SHIFT_W-1:0] : '0;
      cfg.chan[i].rsh  = (s[i] < 7'sd0) ? neg[i][SHIFT_W-1:0] : '0;
    end
    all_m   = m[0] | m[1] | m[2] | rsv;
    tb_all  = top_bit(all_m);
    // (h + 8) / 8 is the byte index of the top bit plus one
    cfg.bpp = tb_all.found ? ({1'b0, tb_all.idx[4:3]} + BPP_W'(1)) : '0;
  end

endmodule
`default_nettype wire

// ===== hdl/pbfc_convert.sv =====
`default_nettype none
module pbfc_convert
  import pbfc_pkg::*;
(
  input  wire logic       func,
  input  wire logic [PIX_W-1:0] pixel,
  input  wire conv_cfg_t  cfg,
  output conv_res_t       res
);

  logic [PIX_W-1:0] chan_val [NUM_CHAN];
  logic [PIX_W-1:0] merged;

  always_comb begin
    merged = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (!func) begin
        chan_val[i] = ((pixel << cfg.chan[i].lsh) >> cfg.chan[i].rsh) & cfg.chan[i].mask;
      end else begin
        chan_val[i] = ((pixel & cfg.chan[i].mask) >> cfg.chan[i].lsh) << cfg.chan[i].rsh;
      end
      merged = merged | chan_val[i];
    end
  end

  always_comb begin
    case (cfg.fmt)
      FMT_BLT_ONLY: begin
        res.pixel = '0;
        res.bpp   = '0;
        res.err   = 1'b1;
      end
      FMT_BGRA: begin
        res.pixel = pixel;
        res.bpp   = BPP_W'(4);
        res.err   = 1'b0;
      end
      default: begin
        res.pixel = merged;
        res.bpp   = cfg.bpp;
        res.err   = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/pixel_bitmask_format_converter.sv =====
`default_nettype none
// Converts one 32-bit pixel per transfer between the transfer layout (blue in
// bits 7:0, green 15:8, red 23:16, reserved 31:24) and the framebuffer layout
// chosen by pixel_format: rgba8888, bgra8888 (word passes unchanged), bit mask
// (red/green/blue/reserved masks from cfg) or blt only (flags format_error,
// returns zero). func 0 packs into the framebuffer layout, func 1 unpacks.
// Each channel shift comes from the highest set bit of its mask, and
// bytes_per_pixel from the highest set bit of all four masks together.
// Throughput is one pixel per cycle while out_ch.ready holds; the path from input
// transfer to output transfer is one input register, then the mask/barrel-shift
// path, then the output register. The output register lets a new pixel in
// while a result waits. The user must write configuration through cfg_* only
// while no pixel is in flight; the block itself does not enforce this.
module pixel_bitmask_format_converter
  import pbfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PIX_W-1:0]     cfg_wdata,
  pbfc_in_if.sink                   in_ch,
  pbfc_out_if.source                out_ch
);

`include "pixel_bitmask_format_converter_assert.svh"

  // configuration registers
  logic [1:0]       fmt_r;
  logic [PIX_W-1:0] mask_red_r;
  logic [PIX_W-1:0] mask_green_r;
  logic [PIX_W-1:0] mask_blue_r;
  logic [PIX_W-1:0] rsv_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= FMT_BGRA;
      mask_red_r   <= '0;
      mask_green_r <= '0;
      mask_blue_r  <= '0;
      rsv_mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT:  fmt_r        <= cfg_wdata[1:0];
        CFG_RED_MASK:      mask_red_r   <= cfg_wdata;
        CFG_GREEN_MASK:    mask_green_r <= cfg_wdata;
        CFG_BLUE_MASK:     mask_blue_r  <= cfg_wdata;
        CFG_RESERVED_MASK: rsv_mask_r   <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // per-channel shifts and bytes per pixel, from the config registers only
  conv_cfg_t conv_cfg;

  pbfc_shift_calc u_shift_calc (
    .fmt           (fmt_r),
    .mask_red      (mask_red_r),
    .mask_green    (mask_green_r),
    .mask_blue     (mask_blue_r),
    .reserved_mask (rsv_mask_r),
    .cfg           (conv_cfg)
  );

  // pipeline handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_accept;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input register, payload only
  logic             s1_func_r;
  logic [PIX_W-1:0] s1_pixel_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r  <= in_ch.func;
      s1_pixel_r <= in_ch.pixel_in;
    end
  end

  // mask and shift datapath
  conv_res_t conv_nxt;

  pbfc_convert u_convert (
    .func  (s1_func_r),
    .pixel (s1_pixel_r),
    .cfg   (conv_cfg),
    .res   (conv_nxt)
  );

  // output register
  conv_res_t out_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= conv_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pixel_out       = out_r.pixel;
  assign out_ch.bytes_per_pixel = out_r.bpp;
  assign out_ch.format_error    = out_r.err;

  // a transfer in always lands in the input register
  `PBFC_ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid_r)
  // input side only stalls when both registers are full
  `PBFC_ASSERT_NOW(a_stall_only_full, !in_ch.ready, s1_valid_r && out_valid_r)
  // a stalled input register keeps its item
  `PBFC_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r)
  // error results carry zero pixel and zero bytes per pixel
  `PBFC_ASSERT_NOW(a_err_zero, out_valid_r && out_r.err, out_r.pixel == '0 && out_r.bpp == '0)
  // bytes per pixel never exceeds four
  `PBFC_ASSERT_NOW(a_bpp_range, out_valid_r, out_r.bpp <= BPP_W'(4))

endmodule
`default_nettype wire
